// File: rtl/cdl_pkg.sv
// Shared types, codes and defaults for the cursor deque list.
`default_nettype none

package cdl_pkg;

    // Default configuration of the node pool.
    localparam int unsigned POOL_DEPTH_DEF = 16;
    localparam int unsigned DATA_WIDTH_DEF = 32;

    // Fixed widths of the transaction fields.
    localparam int unsigned KIND_W    = 3;
    localparam int unsigned VALUE_W   = 32;
    localparam int unsigned STATUS_W  = 3;
    localparam int unsigned ENTRIES_W = 5;

    // Request kinds.
    localparam logic [KIND_W-1:0] K_ADD_FRONT = 3'd0;
    localparam logic [KIND_W-1:0] K_ADD_BACK  = 3'd1;
    localparam logic [KIND_W-1:0] K_FIRST     = 3'd2;
    localparam logic [KIND_W-1:0] K_NEXT      = 3'd3;
    localparam logic [KIND_W-1:0] K_PREV      = 3'd4;
    localparam logic [KIND_W-1:0] K_LAST      = 3'd5;
    localparam logic [KIND_W-1:0] K_DELETE    = 3'd6;
    localparam logic [KIND_W-1:0] K_NOP       = 3'd7;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_AT_END    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_AT_START  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NO_CURSOR = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd5;

    typedef struct packed {
        logic [KIND_W-1:0]         kind;
        logic signed [VALUE_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic signed [VALUE_W-1:0] data;
        logic [STATUS_W-1:0]       status;
        logic [ENTRIES_W-1:0]      entries;
    } t_res;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;  // latch the request and launch the first memory reads
        logic exec;   // evaluate the request and perform the main updates
        logic link;   // patch the old end node after an add
        logic fetch;  // capture the neighbor value after a cursor step
        logic load;   // move the finished result into the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_link;
        logic need_fetch;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

// File: rtl/cdl_ctrl.sv
// Sequencing state machine of the cursor deque list.
`default_nettype none

module cdl_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire cdl_pkg::t_sts i_sts,
    output cdl_pkg::t_cmd      o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_LINK  = 3'd2;
    localparam logic [2:0] S_FETCH = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_sts.need_link) begin
                    n_state = S_LINK;
                end else if (i_sts.need_fetch) begin
                    n_state = S_FETCH;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_LINK: begin
                o_cmd.link = 1'b1;
                n_state    = S_DONE;
            end
            S_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

`default_nettype wire

// File: rtl/cdl_dp.sv
// Datapath of the cursor deque list: node memories, free stack, pointers and result.
`default_nettype none

module cdl_dp #(
    parameter int unsigned POOL_DEPTH = cdl_pkg::POOL_DEPTH_DEF,
    parameter int unsigned DATA_WIDTH = cdl_pkg::DATA_WIDTH_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire cdl_pkg::t_req i_req,
    input  wire cdl_pkg::t_cmd i_cmd,
    output cdl_pkg::t_sts      o_sts,
    input  wire logic          i_out_stall,
    output logic               o_out_valid,
    output cdl_pkg::t_res      o_out_res
);

    localparam int unsigned AW = $clog2(POOL_DEPTH);
    localparam int unsigned CW = $clog2(POOL_DEPTH + 1);

    // Node memories and the free stack.
    logic [DATA_WIDTH-1:0] m_value [POOL_DEPTH];
    logic [AW-1:0]         m_next  [POOL_DEPTH];
    logic [AW-1:0]         m_prev  [POOL_DEPTH];
    logic [AW-1:0]         m_stack [POOL_DEPTH];

    logic [DATA_WIDTH-1:0] rd_value;
    logic [AW-1:0]         rd_next;
    logic [AW-1:0]         rd_prev;
    logic [AW-1:0]         rd_stack;

    // List pointers and counters.
    logic [AW-1:0] r_front, n_front;
    logic [AW-1:0] r_back, n_back;
    logic [AW-1:0] r_cur, n_cur;
    logic          r_cur_valid, n_cur_valid;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_free_top, n_free_top;
    // Lowest stack depth ever reached; positions below it were never written and stand for their own index.
    logic [CW-1:0] r_low, n_low;

    // Request and scratch registers.
    logic [cdl_pkg::KIND_W-1:0] r_kind;
    logic [DATA_WIDTH-1:0]      r_value;
    logic [AW-1:0]              r_new, n_new;
    logic [AW-1:0]              r_link_addr, n_link_addr;
    logic                       r_link_front, n_link_front;
    cdl_pkg::t_res              r_res, n_res;
    cdl_pkg::t_res              r_out;
    logic                       r_out_valid;

    // Memory port controls.
    logic                  we_value, we_next, we_prev, we_stack;
    logic [AW-1:0]         wa_value, wa_next, wa_prev, wa_stack;
    logic [DATA_WIDTH-1:0] wd_value;
    logic [AW-1:0]         wd_next, wd_prev, wd_stack;
    logic [AW-1:0]         ra_value;

    logic [CW-1:0] top_m1;
    logic          fresh;
    logic [AW-1:0] new_node;
    logic          is_front, is_back;

    assign top_m1   = r_free_top - CW'(1);
    assign fresh    = (top_m1 < r_low);
    assign new_node = fresh ? AW'(top_m1) : rd_stack;
    assign is_front = (r_cur == r_front);
    assign is_back  = (r_cur == r_back);

    // The value port reads the node that a request looks at first, then the
    // neighbor reached by a cursor step.
    always_comb begin
        if (i_cmd.exec) begin
            ra_value = (r_kind == cdl_pkg::K_NEXT) ? rd_next : rd_prev;
        end else if (i_req.kind == cdl_pkg::K_FIRST) begin
            ra_value = r_front;
        end else if (i_req.kind == cdl_pkg::K_LAST) begin
            ra_value = r_back;
        end else begin
            ra_value = r_cur;
        end
    end

    always_comb begin
        n_front      = r_front;
        n_back       = r_back;
        n_cur        = r_cur;
        n_cur_valid  = r_cur_valid;
        n_count      = r_count;
        n_free_top   = r_free_top;
        n_low        = r_low;
        n_new        = r_new;
        n_link_addr  = r_link_addr;
        n_link_front = r_link_front;
        n_res        = r_res;
        o_sts        = '0;
        we_value     = 1'b0;
        wa_value     = new_node;
        wd_value     = r_value;
        we_next      = 1'b0;
        wa_next      = new_node;
        wd_next      = new_node;
        we_prev      = 1'b0;
        wa_prev      = new_node;
        wd_prev      = new_node;
        we_stack     = 1'b0;
        wa_stack     = AW'(r_free_top);
        wd_stack     = r_cur;

        if (i_cmd.exec) begin
            n_res.data   = '0;
            n_res.status = cdl_pkg::ST_OK;
            case (r_kind)
                cdl_pkg::K_ADD_FRONT, cdl_pkg::K_ADD_BACK: begin
                    if (r_free_top == '0) begin
                        n_res.status = cdl_pkg::ST_FULL;
                    end else begin
                        we_value    = 1'b1;
                        we_next     = 1'b1;
                        we_prev     = 1'b1;
                        n_free_top  = top_m1;
                        if (fresh) begin
                            n_low = top_m1;
                        end
                        n_cur       = new_node;
                        n_cur_valid = 1'b1;
                        n_count     = r_count + CW'(1);
                        n_new       = new_node;
                        if (r_count == '0) begin
                            n_front = new_node;
                            n_back  = new_node;
                        end else if (r_kind == cdl_pkg::K_ADD_FRONT) begin
                            wd_next        = r_front;
                            n_front        = new_node;
                            n_link_addr    = r_front;
                            n_link_front   = 1'b1;
                            o_sts.need_link = 1'b1;
                        end else begin
                            wd_prev        = r_back;
                            n_back         = new_node;
                            n_link_addr    = r_back;
                            n_link_front   = 1'b0;
                            o_sts.need_link = 1'b1;
                        end
                    end
                end
                cdl_pkg::K_FIRST, cdl_pkg::K_LAST: begin
                    if (r_count == '0) begin
                        n_res.status = cdl_pkg::ST_EMPTY;
                    end else begin
                        n_cur       = (r_kind == cdl_pkg::K_FIRST) ? r_front : r_back;
                        n_cur_valid = 1'b1;
                        n_res.data  = cdl_pkg::VALUE_W'(rd_value);
                    end
                end
                cdl_pkg::K_NEXT, cdl_pkg::K_PREV, cdl_pkg::K_DELETE: begin
                    if (r_count == '0) begin
                        n_res.status = cdl_pkg::ST_EMPTY;
                    end else if (!r_cur_valid) begin
                        n_res.status = cdl_pkg::ST_NO_CURSOR;
                    end else if (r_kind == cdl_pkg::K_NEXT) begin
                        if (is_back) begin
                            n_res.status = cdl_pkg::ST_AT_END;
                        end else begin
                            n_cur            = rd_next;
                            o_sts.need_fetch = 1'b1;
                        end
                    end else if (r_kind == cdl_pkg::K_PREV) begin
                        if (is_front) begin
                            n_res.status = cdl_pkg::ST_AT_START;
                        end else begin
                            n_cur            = rd_prev;
                            o_sts.need_fetch = 1'b1;
                        end
                    end else begin
                        n_res.data = cdl_pkg::VALUE_W'(rd_value);
                        wa_next    = rd_prev;
                        wa_prev    = rd_next;
                        if (is_front && is_back) begin
                            n_front = '0;
                            n_back  = '0;
                        end else if (is_front) begin
                            we_prev = 1'b1;
                            wd_prev = rd_next;
                            n_front = rd_next;
                        end else if (is_back) begin
                            we_next = 1'b1;
                            wd_next = rd_prev;
                            n_back  = rd_prev;
                        end else begin
                            we_next = 1'b1;
                            wd_next = rd_next;
                            we_prev = 1'b1;
                            wd_prev = rd_prev;
                        end
                        if (r_free_top < CW'(POOL_DEPTH)) begin
                            we_stack   = 1'b1;
                            n_free_top = r_free_top + CW'(1);
                        end
                        n_count     = r_count - CW'(1);
                        n_cur_valid = 1'b0;
                        n_cur       = '0;
                    end
                end
                default: begin
                end
            endcase
            n_res.entries = cdl_pkg::ENTRIES_W'(n_count);
        end else if (i_cmd.link) begin
            if (r_link_front) begin
                we_prev = 1'b1;
                wa_prev = r_link_addr;
                wd_prev = r_new;
            end else begin
                we_next = 1'b1;
                wa_next = r_link_addr;
                wd_next = r_new;
            end
        end else if (i_cmd.fetch) begin
            n_res.data = cdl_pkg::VALUE_W'(rd_value);
        end

        o_sts.out_free = !r_out_valid || !i_out_stall;
    end

    // Memories: one write and one registered read per cycle each.
    always_ff @(posedge i_clk) begin
        if (we_value) begin
            m_value[wa_value] <= wd_value;
        end
        rd_value <= m_value[ra_value];
    end

    always_ff @(posedge i_clk) begin
        if (we_next) begin
            m_next[wa_next] <= wd_next;
        end
        rd_next <= m_next[r_cur];
    end

    always_ff @(posedge i_clk) begin
        if (we_prev) begin
            m_prev[wa_prev] <= wd_prev;
        end
        rd_prev <= m_prev[r_cur];
    end

    always_ff @(posedge i_clk) begin
        if (we_stack) begin
            m_stack[wa_stack] <= wd_stack;
        end
        rd_stack <= m_stack[AW'(top_m1)];
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front     <= '0;
            r_back      <= '0;
            r_cur       <= '0;
            r_cur_valid <= 1'b0;
            r_count     <= '0;
            r_free_top  <= CW'(POOL_DEPTH);
            r_low       <= CW'(POOL_DEPTH);
            r_out_valid <= 1'b0;
        end else begin
            r_front     <= n_front;
            r_back      <= n_back;
            r_cur       <= n_cur;
            r_cur_valid <= n_cur_valid;
            r_count     <= n_count;
            r_free_top  <= n_free_top;
            r_low       <= n_low;
            if (i_cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_kind  <= i_req.kind;
            r_value <= DATA_WIDTH'($signed(i_req.value));
        end
        if (i_cmd.load) begin
            r_out <= r_res;
        end
        r_new        <= n_new;
        r_link_addr  <= n_link_addr;
        r_link_front <= n_link_front;
        r_res        <= n_res;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out;

endmodule

`default_nettype wire

// File: rtl/cursor_deque_list.sv
// Top level of the cursor deque list: a doubly linked list with a cursor in a node pool.
//
// Usage: requests arrive on the input channel (i_in_valid, o_in_stall, i_in_req) and each
// one yields exactly one result transaction on the output channel (o_out_valid,
// i_out_stall, o_out_res). A transaction moves at a rising edge where valid is high and
// stall is low. The request kind selects add at front or back, move the cursor to the
// first or last entry, step it forward or back, delete the entry under the cursor, or do nothing.
// Timing: a request is taken in the idle state and evaluated in the cycle after; its result
// then enters the output register in the done state, after a link state for an add to a
// non-empty list (second link write) and after a fetch state for a cursor step (dependent
// value read). The input is open again the cycle after the result is loaded, so a request is
// taken only once the one before it is finished; the dependent registered reads of the node
// memories set this sequence. A finished result may wait in the output register while the
// next request is accepted and evaluated; if the receiver keeps stalling, the block holds
// that next result and the input stays stalled until the output register frees up.
// Reset (synchronous, active low) empties the list, clears the cursor and returns every
// node to the free pool at once; node contents are undefined until written.
`default_nettype none

module cursor_deque_list #(
    parameter int unsigned POOL_DEPTH = cdl_pkg::POOL_DEPTH_DEF,
    parameter int unsigned DATA_WIDTH = cdl_pkg::DATA_WIDTH_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire cdl_pkg::t_req i_in_req,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output cdl_pkg::t_res      o_out_res
);

    cdl_pkg::t_cmd cmd;
    cdl_pkg::t_sts sts;

    // The controller only sequences; every pointer and memory lives in the datapath.
    cdl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    cdl_dp #(
        .POOL_DEPTH (POOL_DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_in_req),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_res   (o_out_res)
    );

endmodule

`default_nettype wire
